// ===== hw/rtl/pmu_pkg.sv =====
// ----------------------------------------------------------------------------
// Particle motion update package
// Shared widths, constants, register indexes and payload types.
// ----------------------------------------------------------------------------
package pmu_pkg;

	localparam int PartWidth = 16;
	localparam int VecWidth = 3 * PartWidth;

	localparam logic [15:0] TimeStepReset = 16'd1092;
	localparam logic [15:0] RetireHeightReset = 16'd1920;

	localparam logic [0:0] RegTimeStep = 1'd0;
	localparam logic [0:0] RegRetireHeight = 1'd1;

	typedef struct packed {
		logic [15:0] shrink_rate;
		logic signed [15:0] scale;
		logic [15:0] turn_factor;
		logic [15:0] speed;
		logic [VecWidth-1:0] direction_change;
		logic [VecWidth-1:0] direction;
		logic [VecWidth-1:0] position;
	} pmu_in_t;

	typedef struct packed {
		logic retired;
		logic signed [15:0] new_scale;
		logic [VecWidth-1:0] new_direction;
		logic [VecWidth-1:0] new_position;
	} pmu_out_t;

endpackage

// ===== hw/rtl/pmu_isqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 64-bit value, one result bit per stage, fully
// pipelined with a shared enable. Side data travels along with the operand.
// ----------------------------------------------------------------------------
module pmu_isqrt #(
	parameter int SideWidth = 8
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [63:0]          rad,
	input  logic [SideWidth-1:0] side_in,
	output logic [31:0]          root,
	output logic [SideWidth-1:0] side_out
);

	logic [65:0]          rem_q  [33];
	logic [31:0]          res_q  [33];
	logic [63:0]          rad_q  [33];
	logic [SideWidth-1:0] side_q [33];

	assign rem_q[0] = '0;
	assign res_q[0] = '0;
	assign rad_q[0] = rad;
	assign side_q[0] = side_in;

	for (genvar k = 0; k < 32; k++) begin : g_stage
		logic [65:0] trial;
		logic [65:0] rem_sh;
		always_comb begin
			rem_sh = {rem_q[k][63:0], rad_q[k][63:62]};
			trial = {32'd0, res_q[k], 2'b01};
		end
		logic [65:0] rem_r;
		logic [31:0] res_r;
		logic [63:0] rad_r;
		logic [SideWidth-1:0] side_r;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_sh >= trial) begin
					rem_r <= rem_sh - trial;
					res_r <= {res_q[k][30:0], 1'b1};
				end else begin
					rem_r <= rem_sh;
					res_r <= {res_q[k][30:0], 1'b0};
				end
				rad_r <= {rad_q[k][61:0], 2'b00};
				side_r <= side_q[k];
			end
		end
		assign rem_q[k+1] = rem_r;
		assign res_q[k+1] = res_r;
		assign rad_q[k+1] = rad_r;
		assign side_q[k+1] = side_r;
	end

	assign root = res_q[32];
	assign side_out = side_q[32];

endmodule

// ===== hw/rtl/pmu_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined truncating divider
// Unsigned restoring division, one quotient bit per stage, with a shared
// enable. Side data travels along with the operands.
// ----------------------------------------------------------------------------
module pmu_div #(
	parameter int NumWidth  = 40,
	parameter int DenWidth  = 33,
	parameter int SideWidth = 8
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [NumWidth-1:0]  num,
	input  logic [DenWidth-1:0]  den,
	input  logic [SideWidth-1:0] side_in,
	output logic [NumWidth-1:0]  quo,
	output logic [SideWidth-1:0] side_out
);

	localparam int RemWidth = DenWidth + 1;

	logic [RemWidth-1:0]  rem_q  [NumWidth+1];
	logic [NumWidth-1:0]  num_q  [NumWidth+1];
	logic [DenWidth-1:0]  den_q  [NumWidth+1];
	logic [SideWidth-1:0] side_q [NumWidth+1];

	assign rem_q[0] = '0;
	assign num_q[0] = num;
	assign den_q[0] = den;
	assign side_q[0] = side_in;

	for (genvar k = 0; k < NumWidth; k++) begin : g_stage
		logic [RemWidth-1:0] rem_sh;
		logic [RemWidth-1:0] rem_r;
		logic [NumWidth-1:0] num_r;
		logic [DenWidth-1:0] den_r;
		logic [SideWidth-1:0] side_r;
		assign rem_sh = {rem_q[k][RemWidth-2:0], num_q[k][NumWidth-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_sh >= {1'b0, den_q[k]}) begin
					rem_r <= rem_sh - {1'b0, den_q[k]};
					num_r <= {num_q[k][NumWidth-2:0], 1'b1};
				end else begin
					rem_r <= rem_sh;
					num_r <= {num_q[k][NumWidth-2:0], 1'b0};
				end
				den_r <= den_q[k];
				side_r <= side_q[k];
			end
		end
		assign rem_q[k+1] = rem_r;
		assign num_q[k+1] = num_r;
		assign den_q[k+1] = den_r;
		assign side_q[k+1] = side_r;
	end

	assign quo = num_q[NumWidth];
	assign side_out = side_q[NumWidth];

endmodule

// ===== hw/rtl/particle_motion_update.sv =====
// ----------------------------------------------------------------------------
// Particle motion update
// Advances one particle per word by one time step: position, normalized
// direction, shrinking scale and a retired flag.
// Throughput: one word per cycle; the whole pipeline advances when the
// output register is free, so a stall holds every stage in place.
// Reset clears all valid bits and loads the registers with their defaults.
// ----------------------------------------------------------------------------
module particle_motion_update
	import pmu_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  pmu_in_t                     in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output pmu_out_t                    out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [0:0]                  cfg_index,
	input  logic [15:0]                 cfg_data
);

	localparam int W = PartWidth;
	localparam int DivLat = 41;
	localparam int SqLat = 32;
	localparam int Lat = 3 + SqLat + 1 + DivLat;

	logic [15:0] time_step_q;
	logic [15:0] retire_height_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= TimeStepReset;
			retire_height_q <= RetireHeightReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				RegTimeStep:     time_step_q <= cfg_data;
				RegRetireHeight: retire_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Payload fields.
	logic [W-1:0]  pos_in [3];
	logic [W-1:0]  dir_in [3];
	logic [W-1:0]  chg_in [3];
	logic [15:0]   speed_in, turn_in, shrink_in;
	logic signed [15:0] scale_in;
	assign {shrink_in, scale_in, turn_in, speed_in} = in_data[3*3*W+63:3*3*W];
	for (genvar i = 0; i < 3; i++) begin : g_unpack
		assign pos_in[i] = in_data[i*W+:W];
		assign dir_in[i] = in_data[3*W+i*W+:W];
		assign chg_in[i] = in_data[6*W+i*W+:W];
	end

	// Output register and pipeline enable.
	logic out_valid_q;
	logic en;
	logic [Lat-1:0] vld_q;
	assign en = !out_valid_q || out_ready;
	assign in_ready = en;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[Lat-2:0], in_valid};
			out_valid_q <= vld_q[Lat-1];
		end
	end

	// Stage 1: products.
	logic [31:0] tss_s1;
	logic [31:0] dec_prod_s1;
	logic signed [W+16:0] turn_s1 [3];
	logic [W-1:0] pos_s1 [3];
	logic [W-1:0] dir_s1 [3];
	logic signed [15:0] scale_s1;
	logic signed [15:0] rh_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			tss_s1 <= time_step_q * speed_in;
			dec_prod_s1 <= time_step_q * shrink_in;
			for (int i = 0; i < 3; i++) begin
				turn_s1[i] <= $signed(chg_in[i]) * $signed({1'b0, turn_in});
				pos_s1[i] <= pos_in[i];
				dir_s1[i] <= dir_in[i];
			end
			scale_s1 <= scale_in;
			rh_s1 <= retire_height_q;
		end
	end

	// Stage 2: position delta products, turn sums, scale.
	logic signed [W+33:0] pd_s2 [3];
	logic signed [W+9:0] sum_s2 [3];
	logic [W-1:0] pos_s2 [3];
	logic signed [15:0] nscale_s2;
	logic signed [15:0] rh_s2;
	logic [16:0] dec_w;
	logic signed [17:0] ns_w;
	always_comb begin
		dec_w = 17'((dec_prod_s1 + 32'd32768) >> 16);
		ns_w = 18'(scale_s1) - 18'($signed({1'b0, dec_w}));
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pd_s2[i] <= $signed({1'b0, tss_s1}) * $signed(dir_s1[i]);
				sum_s2[i] <= (W+10)'($signed(dir_s1[i]))
					+ (W+10)'((turn_s1[i] + (W+17)'(128)) >>> 8);
				pos_s2[i] <= pos_s1[i];
			end
			nscale_s2 <= (ns_w < -18'sd32768) ? -16'sd32768 : ns_w[15:0];
			rh_s2 <= rh_s1;
		end
	end

	// Stage 3: new position, squares.
	localparam logic signed [W+1:0] PHi = (W+2)'((1 <<< (W-1)) - 1);
	localparam logic signed [W+1:0] PLo = -PHi - (W+2)'(1);
	logic [W-1:0] np_s3 [3];
	logic [63:0]  sq_s3 [3];
	logic signed [W+9:0] sum_s3 [3];
	logic signed [15:0] nscale_s3;
	logic signed [15:0] rh_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [W+9:0] np;
				logic signed [2*W+19:0] sq;
				np = (W+10)'($signed(pos_s2[i]))
					+ (W+10)'((pd_s2[i] + (W+34)'(1 <<< 23)) >>> 24);
				sq = (2*W+20)'(sum_s2[i]) * (2*W+20)'(sum_s2[i]);
				np_s3[i] <= (np > PHi) ? PHi[W-1:0] : ((np < PLo) ? PLo[W-1:0] : np[W-1:0]);
				sq_s3[i] <= 64'(sq);
				sum_s3[i] <= sum_s2[i];
			end
			nscale_s3 <= nscale_s2;
			rh_s3 <= rh_s2;
		end
	end

	// Stage 4: sum of squares and range choice, retired flag.
	logic [63:0] ssq;
	logic        big;
	assign ssq = sq_s3[0] + sq_s3[1] + sq_s3[2];
	assign big = ssq >= (64'd1 << 46);
	localparam int SideW = 3*(W+10) + 3*W + 16 + 3;
	logic [SideW-1:0] side_a, side_b;
	logic retired_w;
	assign retired_w = (nscale_s3 <= 0) || ($signed(np_s3[1]) >= (W)'(rh_s3));
	assign side_a = {sum_s3[2], sum_s3[1], sum_s3[0], np_s3[2], np_s3[1], np_s3[0],
		nscale_s3, retired_w, big, ssq == 64'd0};

	logic [31:0] root;
	pmu_isqrt #(.SideWidth(SideW)) u_sqrt (
		.clk(clk), .en(en),
		.rad(big ? ssq : {ssq[47:0], 16'd0}),
		.side_in(side_a), .root(root), .side_out(side_b)
	);

	logic [32:0] len_s5;
	logic [SideW-1:0] side_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			len_s5 <= {root, 1'b0};
			side_s5 <= side_b;
		end
	end

	logic signed [W+9:0] sm [3];
	assign {sm[2], sm[1], sm[0]} = side_s5[SideW-1 -: 3*(W+10)];
	logic bigs;
	assign bigs = side_s5[1];

	logic [SideW-1:0] side_d [3];
	logic [DivLat-1:0] quo [3];
	for (genvar i = 0; i < 3; i++) begin : g_div
		logic [W+9:0] mag;
		logic [DivLat-1:0] num;
		assign mag = sm[i][W+9] ? (W+10)'(-sm[i]) : sm[i];
		assign num = bigs ? DivLat'({mag, 9'd0}) + DivLat'(len_s5 >> 1)
			: DivLat'({mag, 17'd0}) + DivLat'(len_s5 >> 1);
		pmu_div #(.NumWidth(DivLat), .DenWidth(33), .SideWidth(SideW)) u_div (
			.clk(clk), .en(en), .num(num),
			.den(len_s5 == 33'd0 ? 33'd2 : len_s5),
			.side_in(side_s5), .quo(quo[i]), .side_out(side_d[i])
		);
	end

	// Final stage: sign, saturation, output register.
	logic [W-1:0] nd [3];
	logic signed [W+9:0] sf [3];
	assign {sf[2], sf[1], sf[0]} = side_d[0][SideW-1 -: 3*(W+10)];
	for (genvar i = 0; i < 3; i++) begin : g_fin
		logic signed [DivLat:0] q;
		assign q = sf[i][W+9] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
		assign nd[i] = side_d[0][0] ? '0
			: (q > (DivLat+1)'(PHi)) ? PHi[W-1:0]
			: (q < (DivLat+1)'(PLo)) ? PLo[W-1:0] : q[W-1:0];
	end

	logic [SideW-1:0] sd;
	assign sd = side_d[0];
	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= {sd[2], sd[18:3], nd[2], nd[1], nd[0], sd[3*W+18:19]};
		end
	end

endmodule
